// ===== rtl/core/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and helpers of the packed sample unpacker.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int ROW_W           = 17;
    localparam int MAX_ROW_SAMPLES = 65536;
    localparam int CFG_DATA_W      = 17;
    localparam int CFG_INDEX_W     = 2;

    // Bits-per-sample codes
    typedef enum logic [2:0] {
        CODE_W1  = 3'd0,
        CODE_W2  = 3'd1,
        CODE_W4  = 3'd2,
        CODE_W8  = 3'd3,
        CODE_W16 = 3'd4,
        CODE_W32 = 3'd5
    } t_code;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LEN     = 2'd2;

    // Gathered word handed from the byte gatherer to the slicer
    typedef struct packed {
        logic [31:0] value;
        t_code       code;
    } t_word;

    // Live configuration as seen by the datapath
    typedef struct packed {
        t_code            code;
        logic             invert;
        logic [ROW_W-1:0] row_len;
    } t_cfg;

    // Map the raw register code; unused codes act as 8-bit samples
    function automatic t_code decode_code(input logic [2:0] raw);
        t_code c;
        unique case (raw)
            3'd0:    c = CODE_W1;
            3'd1:    c = CODE_W2;
            3'd2:    c = CODE_W4;
            3'd4:    c = CODE_W16;
            3'd5:    c = CODE_W32;
            default: c = CODE_W8;
        endcase
        return c;
    endfunction

    // Mask of valid sample bits for a code
    function automatic logic [31:0] sample_mask(input t_code c);
        logic [31:0] m;
        unique case (c)
            CODE_W1:  m = 32'h0000_0001;
            CODE_W2:  m = 32'h0000_0003;
            CODE_W4:  m = 32'h0000_000f;
            CODE_W8:  m = 32'h0000_00ff;
            CODE_W16: m = 32'h0000_ffff;
            default:  m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/psu_gather.sv =====
// ----------------------------------------------------------------------------
// psu_gather
// Collects input bytes into sample words; wide samples build up over several
// bytes in little-endian order, narrow ones pass on with every byte.
// ----------------------------------------------------------------------------
module psu_gather
    import psu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_code      i_code,
    input  logic       i_accept,
    input  logic [7:0] i_raw_byte,
    output logic       o_word_valid,
    output t_word      o_word
);

    logic [1:0]  r_phase, n_phase;
    logic [23:0] r_acc, n_acc;

    // Build the next gather state and the word completed by this item
    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        o_word_valid = 1'b0;
        o_word.code  = i_code;
        o_word.value = {24'd0, i_raw_byte};
        if (i_accept) begin
            unique case (i_code)
                CODE_W16: begin
                    if (r_phase == 2'd0) begin
                        n_acc   = {16'd0, i_raw_byte};
                        n_phase = 2'd1;
                    end else begin
                        o_word_valid = 1'b1;
                        o_word.value = {16'd0, i_raw_byte, r_acc[7:0]};
                        n_acc        = '0;
                        n_phase      = 2'd0;
                    end
                end
                CODE_W32: begin
                    if (r_phase != 2'd3) begin
                        n_acc   = r_acc | (24'(i_raw_byte) << {r_phase, 3'b000});
                        n_phase = r_phase + 2'd1;
                    end else begin
                        o_word_valid = 1'b1;
                        o_word.value = {i_raw_byte, r_acc};
                        n_acc        = '0;
                        n_phase      = 2'd0;
                    end
                end
                default: begin
                    o_word_valid = 1'b1;
                    n_acc        = '0;
                    n_phase      = 2'd0;
                end
            endcase
        end
    end

    // Hold the gather state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

endmodule

// ===== rtl/core/psu_slicer.sv =====
// ----------------------------------------------------------------------------
// psu_slicer
// Holds one gathered word, cuts it into samples one per cycle unless stalled,
// applies invert mode, tracks the row position and drives the result register.
// ----------------------------------------------------------------------------
module psu_slicer
    import psu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_word_valid,
    input  t_word       i_word,
    output logic        o_word_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_sample_value,
    output logic        o_row_last
);

    logic             r_word_valid, n_word_valid;
    t_word            r_word;
    logic [2:0]       r_slot, n_slot;
    logic [ROW_W-1:0] r_row_cnt, n_row_cnt;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_sample;
    logic             r_last;

    logic             advance;
    logic             slot_end;
    logic             sample_last;
    logic             word_done;
    logic [2:0]       shamt;
    logic [7:0]       shifted;
    logic [31:0]      raw_sample;
    logic [31:0]      mask;
    logic [31:0]      sample;

    // Pick the current sample out of the held word, most significant first
    always_comb begin
        shamt   = 3'(r_slot << r_word.code[1:0]);
        shifted = r_word.value[7:0] << shamt;
        unique case (r_word.code)
            CODE_W1:  raw_sample = {31'd0, shifted[7]};
            CODE_W2:  raw_sample = {30'd0, shifted[7:6]};
            CODE_W4:  raw_sample = {28'd0, shifted[7:4]};
            default:  raw_sample = r_word.value;
        endcase
        mask   = sample_mask(r_word.code);
        sample = (i_cfg.invert ? ~raw_sample : raw_sample) & mask;
    end

    // Detect the final slot of a word and the final sample of a row
    always_comb begin
        unique case (r_word.code)
            CODE_W1: slot_end = (r_slot == 3'd7);
            CODE_W2: slot_end = (r_slot == 3'd3);
            CODE_W4: slot_end = (r_slot == 3'd1);
            default: slot_end = 1'b1;
        endcase
        sample_last = ({1'b0, r_row_cnt} + {{ROW_W{1'b0}}, 1'b1})
                      >= {1'b0, i_cfg.row_len};
    end

    // Advance one sample whenever the result register can take it
    always_comb begin
        advance      = r_word_valid && (!r_out_valid || i_out_ready);
        word_done    = advance && (slot_end || sample_last);
        o_word_ready = !r_word_valid || word_done;

        n_word_valid = r_word_valid;
        n_slot       = r_slot;
        n_row_cnt    = r_row_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;

        if (advance) begin
            n_out_valid = 1'b1;
            n_slot      = r_slot + 3'd1;
            n_row_cnt   = sample_last ? '0 : r_row_cnt + 1'b1;
        end
        // Drop the pad bits once the row or the word ends
        if (word_done) begin
            n_word_valid = 1'b0;
            n_slot       = 3'd0;
        end
        if (i_word_valid && o_word_ready) begin
            n_word_valid = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= 1'b0;
            r_slot       <= 3'd0;
            r_row_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_word_valid <= n_word_valid;
            r_slot       <= n_slot;
            r_row_cnt    <= n_row_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // Load word and result payloads
    always_ff @(posedge i_clk) begin
        if (i_word_valid && o_word_ready) begin
            r_word <= i_word;
        end
        if (advance) begin
            r_sample <= sample;
            r_last   <= sample_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_sample;
    assign o_row_last     = r_last;

endmodule

// ===== rtl/core/packed_sample_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// packed_sample_unpacker_unit
// Unpacks raw scanline bytes into 1 to 32 bit samples with row marking.
// ----------------------------------------------------------------------------
// One byte enters per cycle while the sample slicer is free. A byte of 1, 2
// or 4 bit samples holds the slicer until its 8, 4 or 2 samples are out (fewer
// when the row ends inside the byte), as the result channel carries one
// sample a cycle; 8-bit bytes flow at one per cycle, and 16 and 32 bit samples
// take 2 and 4 bytes, one byte a cycle, while the output does not stall. Each
// sample passes the word and result registers. Configuration is written with
// i_cfg_we, i_cfg_index and i_cfg_data; write it only while the unit is idle.
module packed_sample_unpacker_unit
    import psu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_raw_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [31:0]            o_sample_value,
    output logic                   o_row_last
);

    logic [2:0]       r_bits_code;
    logic             r_invert;
    logic [ROW_W-1:0] r_row_len;

    t_cfg             cfg;
    logic             word_ready;
    logic             word_valid;
    t_word            word;
    logic             in_accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_code <= 3'd3;
            r_invert    <= 1'b0;
            r_row_len   <= ROW_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SAMPLE_BITS: r_bits_code <= i_cfg_data[2:0];
                REG_INVERT:      r_invert    <= i_cfg_data[0];
                REG_ROW_LEN:     r_row_len   <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the row length into its legal range
    always_comb begin
        cfg.code   = decode_code(r_bits_code);
        cfg.invert = r_invert;
        if (r_row_len == '0) begin
            cfg.row_len = ROW_W'(1);
        end else if (r_row_len > ROW_W'(MAX_ROW_SAMPLES)) begin
            cfg.row_len = ROW_W'(MAX_ROW_SAMPLES);
        end else begin
            cfg.row_len = r_row_len;
        end
    end

    assign o_in_ready = word_ready;
    assign in_accept  = i_in_valid && word_ready;

    psu_gather u_gather (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_code       (cfg.code),
        .i_accept     (in_accept),
        .i_raw_byte   (i_raw_byte),
        .o_word_valid (word_valid),
        .o_word       (word)
    );

    psu_slicer u_slicer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_word_valid   (word_valid),
        .i_word         (word),
        .o_word_ready   (word_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_value (o_sample_value),
        .o_row_last     (o_row_last)
    );

    // A word is only produced by an accepted byte, so the slicer must have room
    a_word_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        word_valid |-> word_ready)
        else $error("gathered word with no room in the slicer");

    // A 16-bit word carries nothing above its two bytes
    a_w16_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (word_valid && word.code == CODE_W16) |-> (word.value[31:16] == 16'd0))
        else $error("16-bit word has stray upper bits");

    // No result is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule
